@@ src/poes_pkg.sv @@
// ----------------------------------------------------------------------------
// poes_pkg
// Shared constants, record types and state codes of the on/off-pulse
// energy statistics block.
// ----------------------------------------------------------------------------
package poes_pkg;

    localparam int MAX_BINS   = 4096;
    localparam int SAMPLE_W   = 16;
    localparam int PEAK_W     = SAMPLE_W - 1;
    localparam int CNT_W      = $clog2(MAX_BINS + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_BINS);
    localparam int SQR_W      = 2 * SAMPLE_W - 1;
    localparam int SQ_W       = SQR_W + $clog2(MAX_BINS);
    localparam int FRAC_SH    = 16;
    localparam int RMS_W      = 24;
    localparam int SQN_W      = 15;
    localparam int DEN_W      = RMS_W + SQN_W;
    localparam int SNR_SH     = 24;
    localparam int DIV_W      = SQ_W + FRAC_SH;
    localparam int SQRT_IN_W  = 2 * RMS_W;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sum_sq;
        logic [PEAK_W-1:0]       peak;
        logic [CNT_W-1:0]        count;
    } t_region;

    typedef struct packed {
        t_region on_acc;
        t_region off_acc;
    } t_snap;

    typedef enum logic {
        AR_DIV,
        AR_SQRT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_rsp;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV_ON,
        BK_SQRT_ON,
        BK_DIV_OFF,
        BK_SQRT_OFF,
        BK_SQRT_N,
        BK_MUL,
        BK_DIV_SNR,
        BK_OUT
    } t_bk_state;

endpackage

@@ src/poes_front.sv @@
// ----------------------------------------------------------------------------
// poes_front
// Squares each sample in one stage and folds it into the on-pulse and
// off-pulse accumulators in the next; the last bin pushes a snapshot.
// ----------------------------------------------------------------------------
module poes_front
    import poes_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_in_on,
    input  logic                       i_in_off,
    input  logic                       i_last_bin,
    input  logic [QCNT_W-1:0]          i_q_count,
    output logic                       o_full,
    output logic                       o_q_push,
    output t_snap                      o_q_data
);

    logic                       r_p_valid;
    logic signed [SAMPLE_W-1:0] r_p_sample;
    logic [SQR_W-1:0]           r_p_sq;
    logic                       r_p_on;
    logic                       r_p_off;
    logic                       r_p_last;
    t_region                    r_on;
    t_region                    r_off;
    t_region                    n_on;
    t_region                    n_off;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [QCNT_W:0]            used;
    logic                       accept;

    function automatic t_region acc_add(t_region r, logic signed [SAMPLE_W-1:0] s,
                                        logic [SQR_W-1:0] sq);
        t_region n;
        n = r;
        if (r.count < CNT_W'(MAX_BINS)) begin
            n.sum    = r.sum + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
            n.sum_sq = r.sum_sq + SQ_W'(sq);
            if ($signed(s) > $signed({1'b0, r.peak})) begin
                n.peak = s[PEAK_W-1:0];
            end
            n.count  = r.count + 1'b1;
        end
        return n;
    endfunction

    assign used    = {1'b0, i_q_count} + (QCNT_W+1)'(r_p_valid & r_p_last);
    assign o_full  = used >= (QCNT_W+1)'(QDEPTH);
    assign accept  = i_push & ~o_full;
    assign sq_full = (2*SAMPLE_W)'(i_sample) * (2*SAMPLE_W)'(i_sample);

    always_comb begin
        n_on  = r_on;
        n_off = r_off;
        if (r_p_valid && r_p_on) begin
            n_on = acc_add(r_on, r_p_sample, r_p_sq);
        end
        if (r_p_valid && r_p_off) begin
            n_off = acc_add(r_off, r_p_sample, r_p_sq);
        end
    end

    assign o_q_push = r_p_valid & r_p_last;
    assign o_q_data = '{on_acc: n_on, off_acc: n_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_on      <= '0;
            r_off     <= '0;
        end else begin
            r_p_valid <= accept;
            if (o_q_push) begin
                r_on  <= '0;
                r_off <= '0;
            end else begin
                r_on  <= n_on;
                r_off <= n_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_sample <= i_sample;
            r_p_sq     <= sq_full[SQR_W-1:0];
            r_p_on     <= i_in_on;
            r_p_off    <= i_in_off;
            r_p_last   <= i_last_bin;
        end
    end

endmodule

@@ src/poes_queue.sv @@
// ----------------------------------------------------------------------------
// poes_queue
// Short queue of accumulator snapshots between the front and the back.
// ----------------------------------------------------------------------------
module poes_queue
    import poes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_snap             i_data,
    input  logic              i_pop,
    output t_snap             o_head,
    output logic              o_nempty,
    output logic [QCNT_W-1:0] o_count
);

    t_snap             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wp;
    logic [QPTR_W-1:0] n_rp;

    assign n_wp     = (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp     = (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign o_head   = r_mem[r_rp];
    assign o_nempty = r_cnt != '0;
    assign o_count  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != QCNT_W'(QDEPTH))
        else $error("Snapshot pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("Snapshot popped from an empty queue.");

endmodule

@@ src/poes_arith.sv @@
// ----------------------------------------------------------------------------
// poes_arith
// Iterative unit shared by all divisions and square roots of a pulse:
// restoring division one quotient bit per cycle, or digit-by-digit square
// root one root bit per cycle.
// ----------------------------------------------------------------------------
module poes_arith
    import poes_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_arith_cmd       i_cmd,
    input  logic [DIV_W-1:0] i_a,
    input  logic [DEN_W-1:0] i_b,
    output t_arith_rsp       o_rsp,
    output logic [DIV_W-1:0] o_res
);

    localparam int REM_W  = DEN_W + 1;
    localparam int ITER_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    t_arith_op        r_op;
    logic [ITER_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [DIV_W-1:0] r_sh;
    logic [RMS_W-1:0] r_root;
    logic [DEN_W-1:0] r_div;

    logic             n_busy;
    logic             n_done;
    t_arith_op        n_op;
    logic [ITER_W-1:0] n_cnt;
    logic [REM_W-1:0] n_rem;
    logic [DIV_W-1:0] n_sh;
    logic [RMS_W-1:0] n_root;
    logic [DEN_W-1:0] n_div;

    logic [REM_W-1:0] div_rem;
    logic [REM_W-1:0] sqrt_rem;
    logic [REM_W-1:0] trial;

    assign div_rem  = {r_rem[REM_W-2:0], r_sh[DIV_W-1]};
    assign sqrt_rem = {r_rem[REM_W-3:0], r_sh[DIV_W-1 -: 2]};
    assign trial    = REM_W'({r_root, 2'b01});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_sh   = r_sh;
        n_root = r_root;
        n_div  = r_div;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_op   = i_cmd.op;
            n_rem  = '0;
            n_root = '0;
            n_div  = i_b;
            if (i_cmd.op == AR_DIV) begin
                n_cnt = ITER_W'(DIV_W);
                n_sh  = i_a;
            end else begin
                n_cnt = ITER_W'(RMS_W);
                n_sh  = {i_a[SQRT_IN_W-1:0], {(DIV_W-SQRT_IN_W){1'b0}}};
            end
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_op == AR_DIV) begin
                if (div_rem >= REM_W'(r_div)) begin
                    n_rem = div_rem - REM_W'(r_div);
                    n_sh  = {r_sh[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = div_rem;
                    n_sh  = {r_sh[DIV_W-2:0], 1'b0};
                end
            end else begin
                n_sh = {r_sh[DIV_W-3:0], 2'b00};
                if (sqrt_rem >= trial) begin
                    n_rem  = sqrt_rem - trial;
                    n_root = {r_root[RMS_W-2:0], 1'b1};
                end else begin
                    n_rem  = sqrt_rem;
                    n_root = {r_root[RMS_W-2:0], 1'b0};
                end
            end
            if (r_cnt == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= AR_DIV;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_sh   <= n_sh;
        r_root <= n_root;
        r_div  <= n_div;
    end

    assign o_rsp = '{busy: r_busy, done: r_done};
    assign o_res = (r_op == AR_DIV) ? r_sh : DIV_W'(r_root);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("Arithmetic unit started while busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy) && !r_busy)
        else $error("Arithmetic unit finished without running.");

endmodule

@@ src/poes_back.sv @@
// ----------------------------------------------------------------------------
// poes_back
// Takes one snapshot at a time, derives the rms values and the S/N with the
// shared arithmetic unit, and holds the finished result until it is popped.
// ----------------------------------------------------------------------------
module poes_back
    import poes_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_snap                    i_head,
    input  logic                     i_q_nempty,
    output logic                     o_q_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic [PEAK_W-1:0]        o_on_peak,
    output logic [PEAK_W-1:0]        o_off_peak,
    output logic signed [SUM_W-1:0]  o_on_total,
    output logic signed [SUM_W-1:0]  o_off_total,
    output logic [RMS_W-1:0]         o_on_rms,
    output logic [RMS_W-1:0]         o_off_rms,
    output logic signed [RMS_W-1:0]  o_snr,
    output logic [CNT_W-1:0]         o_on_bins,
    output logic [CNT_W-1:0]         o_off_bins,
    output logic                     o_off_valid
);

    localparam logic [RMS_W-1:0] SNR_POS_MAX = {1'b0, {(RMS_W-1){1'b1}}};
    localparam logic [RMS_W-1:0] SNR_NEG_MAX = {1'b1, {(RMS_W-1){1'b0}}};

    t_bk_state        r_state;
    t_bk_state        n_state;
    t_snap            r_snap;
    t_snap            n_snap;
    logic [RMS_W-1:0] r_on_rms;
    logic [RMS_W-1:0] n_on_rms;
    logic [RMS_W-1:0] r_off_rms;
    logic [RMS_W-1:0] n_off_rms;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] n_den;
    logic [RMS_W-1:0] r_snr;
    logic [RMS_W-1:0] n_snr;
    logic             r_res_valid;
    logic             n_res_valid;
    logic             load_res;

    t_arith_cmd       cmd;
    t_arith_rsp       rsp;
    logic [DIV_W-1:0] ar_a;
    logic [DEN_W-1:0] ar_b;
    logic [DIV_W-1:0] ar_res;

    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [RMS_W-1:0] limit;
    logic [RMS_W-1:0] q_sat;
    logic             both_valid;

    poes_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_a     (ar_a),
        .i_b     (ar_b),
        .o_rsp   (rsp),
        .o_res   (ar_res)
    );

    assign neg        = r_snap.on_acc.sum[SUM_W-1];
    assign mag        = neg ? SUM_W'(-r_snap.on_acc.sum) : r_snap.on_acc.sum;
    assign limit      = neg ? SNR_NEG_MAX : SNR_POS_MAX;
    assign both_valid = (r_snap.on_acc.count != '0) && (r_snap.off_acc.count != '0);

    always_comb begin
        priority if (mag == '0) begin
            q_sat = '0;
        end else if (r_den == '0) begin
            q_sat = limit;
        end else if (ar_res > DIV_W'(limit)) begin
            q_sat = limit;
        end else begin
            q_sat = ar_res[RMS_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_snap    = r_snap;
        n_on_rms  = r_on_rms;
        n_off_rms = r_off_rms;
        n_den     = r_den;
        n_snr     = r_snr;
        o_q_pop   = 1'b0;
        load_res  = 1'b0;
        cmd       = '{start: 1'b0, op: AR_DIV};
        ar_a      = '0;
        ar_b      = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_nempty) begin
                    o_q_pop = 1'b1;
                    n_snap  = i_head;
                    cmd     = '{start: 1'b1, op: AR_DIV};
                    ar_a    = {i_head.on_acc.sum_sq, {FRAC_SH{1'b0}}};
                    ar_b    = DEN_W'(i_head.on_acc.count);
                    n_state = BK_DIV_ON;
                end
            end
            BK_DIV_ON: begin
                if (rsp.done) begin
                    cmd     = '{start: 1'b1, op: AR_SQRT};
                    ar_a    = ar_res;
                    n_state = BK_SQRT_ON;
                end
            end
            BK_SQRT_ON: begin
                if (rsp.done) begin
                    n_on_rms = ar_res[RMS_W-1:0];
                    cmd      = '{start: 1'b1, op: AR_DIV};
                    ar_a     = {r_snap.off_acc.sum_sq, {FRAC_SH{1'b0}}};
                    ar_b     = DEN_W'(r_snap.off_acc.count);
                    n_state  = BK_DIV_OFF;
                end
            end
            BK_DIV_OFF: begin
                if (rsp.done) begin
                    cmd     = '{start: 1'b1, op: AR_SQRT};
                    ar_a    = ar_res;
                    n_state = BK_SQRT_OFF;
                end
            end
            BK_SQRT_OFF: begin
                if (rsp.done) begin
                    n_off_rms = ar_res[RMS_W-1:0];
                    cmd       = '{start: 1'b1, op: AR_SQRT};
                    ar_a      = DIV_W'({r_snap.on_acc.count, {FRAC_SH{1'b0}}});
                    n_state   = BK_SQRT_N;
                end
            end
            BK_SQRT_N: begin
                if (rsp.done) begin
                    n_den   = DEN_W'(r_off_rms) * DEN_W'(ar_res[SQN_W-1:0]);
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                cmd     = '{start: 1'b1, op: AR_DIV};
                ar_a    = DIV_W'({mag, {SNR_SH{1'b0}}});
                ar_b    = r_den;
                n_state = BK_DIV_SNR;
            end
            BK_DIV_SNR: begin
                if (rsp.done) begin
                    if (!both_valid) begin
                        n_snr = '0;
                    end else if (neg) begin
                        n_snr = RMS_W'(-q_sat);
                    end else begin
                        n_snr = q_sat;
                    end
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_res_valid || i_pop) begin
                    load_res = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (load_res) begin
            n_res_valid = 1'b1;
        end else if (i_pop && r_res_valid) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snap    <= n_snap;
        r_on_rms  <= n_on_rms;
        r_off_rms <= n_off_rms;
        r_den     <= n_den;
        r_snr     <= n_snr;
        if (load_res) begin
            o_on_peak   <= r_snap.on_acc.peak;
            o_off_peak  <= r_snap.off_acc.peak;
            o_on_total  <= r_snap.on_acc.sum;
            o_off_total <= r_snap.off_acc.sum;
            o_on_rms    <= (r_snap.on_acc.count != '0) ? r_on_rms : '0;
            o_off_rms   <= (r_snap.off_acc.count != '0) ? r_off_rms : '0;
            o_snr       <= r_snr;
            o_on_bins   <= r_snap.on_acc.count;
            o_off_bins  <= r_snap.off_acc.count;
            o_off_valid <= r_snap.off_acc.count != '0;
        end
    end

    assign o_empty = ~r_res_valid;

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == BK_IDLE && i_q_nempty)
        else $error("Snapshot taken outside the idle state.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_pop |-> !load_res)
        else $error("Waiting result overwritten.");

endmodule

@@ src/pulse_on_off_energy_stats_top.sv @@
// ----------------------------------------------------------------------------
// pulse_on_off_energy_stats_top
// Samples are taken at one per cycle while full is low; the result of a
// pulse is computed after its last bin by the shared divide/sqrt unit
// (three divisions and three square roots per pulse). Two finished pulses
// can wait between front and back; beyond that full is raised until the back
// frees a slot. Synchronous reset clears control state and accumulators only.
// ----------------------------------------------------------------------------
module pulse_on_off_energy_stats_top
    import poes_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_in_on,
    input  logic                       i_in_off,
    input  logic                       i_last_bin,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [PEAK_W-1:0]          o_on_peak,
    output logic [PEAK_W-1:0]          o_off_peak,
    output logic signed [SUM_W-1:0]    o_on_total,
    output logic signed [SUM_W-1:0]    o_off_total,
    output logic [RMS_W-1:0]           o_on_rms,
    output logic [RMS_W-1:0]           o_off_rms,
    output logic signed [RMS_W-1:0]    o_snr,
    output logic [CNT_W-1:0]           o_on_bins,
    output logic [CNT_W-1:0]           o_off_bins,
    output logic                       o_off_valid
);

    logic              q_push;
    t_snap             q_data;
    logic              q_pop;
    t_snap             q_head;
    logic              q_nempty;
    logic [QCNT_W-1:0] q_count;

    poes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_sample   (i_sample),
        .i_in_on    (i_in_on),
        .i_in_off   (i_in_off),
        .i_last_bin (i_last_bin),
        .i_q_count  (q_count),
        .o_full     (o_full),
        .o_q_push   (q_push),
        .o_q_data   (q_data)
    );

    poes_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_data),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_nempty (q_nempty),
        .o_count  (q_count)
    );

    poes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_nempty  (q_nempty),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_on_peak   (o_on_peak),
        .o_off_peak  (o_off_peak),
        .o_on_total  (o_on_total),
        .o_off_total (o_off_total),
        .o_on_rms    (o_on_rms),
        .o_off_rms   (o_off_rms),
        .o_snr       (o_snr),
        .o_on_bins   (o_on_bins),
        .o_off_bins  (o_off_bins),
        .o_off_valid (o_off_valid)
    );

endmodule
